>>> src/sorted_priority_queue_unit_assert.svh
// Assertion macros for the sorted priority queue.
// Used by sorted_priority_queue_unit; expects clk and arst_n in scope.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies.
`default_nettype none

package spq_pkg;

	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_PEEK   = 2'd1,
		CMD_POP    = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_e_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_e_t;

	// Broadcast control from the top level to every cell.
	typedef struct packed {
		logic insert;
		logic pop;
	} cell_ctl_t;

endpackage

`default_nettype wire

>>> src/spq_if.sv
// Valid/ready channel interface for commands.
// Depends on spq_pkg.
`default_nettype none

interface spq_cmd_if
	import spq_pkg::*;
();
	logic                      valid;
	logic                      ready;
	cmd_e_t                    command;
	logic signed [VALUE_W-1:0] new_value;

	modport source (output valid, output command, output new_value, input ready);
	modport sink   (input valid, input command, input new_value, output ready);
endinterface

`default_nettype wire

>>> src/spq_rsp_if.sv
// Response channel interface; the count width follows the queue depth.
// Depends on spq_pkg.
`default_nettype none

interface spq_rsp_if
	import spq_pkg::*;
#(
	parameter int CNT_W = 5
) ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] front_value;
	logic                      value_valid;
	status_e_t                 status;
	logic [CNT_W-1:0]          entry_count;

	modport source (output valid, output front_value, output value_valid, output status,
		output entry_count, input ready);
	modport sink   (input valid, input front_value, input value_valid, input status,
		input entry_count, output ready);
endinterface

`default_nettype wire

>>> src/spq_cell.sv
// One slot of the sorted chain: holds a value and shifts with its neighbours.
// Depends on spq_pkg.
`default_nettype none

module spq_cell
	import spq_pkg::*;
(
	input  wire logic                      clk,
	input  wire cell_ctl_t                 ctl,
	input  wire logic signed [VALUE_W-1:0] new_value,
	input  wire logic                      occupied,
	input  wire logic                      at_end,
	input  wire logic                      left_gt,
	input  wire logic signed [VALUE_W-1:0] left_value,
	input  wire logic signed [VALUE_W-1:0] right_value,
	output logic                           gt,
	output logic signed [VALUE_W-1:0]      value
);

	logic signed [VALUE_W-1:0] value_q;

	// Strictly greater keeps equal entries ahead of the new one.
	assign gt    = occupied && (value_q > new_value);
	assign value = value_q;

	always_ff @(posedge clk) begin
		priority if (ctl.insert) begin
			priority if (left_gt) begin
				value_q <= left_value;
			end else if (gt || at_end) begin
				value_q <= new_value;
			end else begin
				value_q <= value_q;
			end
		end else if (ctl.pop) begin
			value_q <= right_value;
		end else begin
			value_q <= value_q;
		end
	end

endmodule

`default_nettype wire

>>> src/sorted_priority_queue_unit.sv
// Channel  | Dir | Payload
// cmd      | in  | command, new_value
// rsp      | out | front_value, value_valid, status, entry_count
//
// One command per cycle unless a held response stalls it: every cell compares
// with the new value in parallel, so the whole insert/pop shift happens in the
// accepting cycle. Response registered at transfer; a held response still
// lets the next command in when rsp.ready is high in the same cycle.
// Reset clears the count and response valid; slot contents stay unknown.
// Depends on spq_pkg, spq_cmd_if, spq_rsp_if, spq_cell and the assertion header.
`default_nettype none
`include "sorted_priority_queue_unit_assert.svh"

module sorted_priority_queue_unit
	import spq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	spq_cmd_if.sink    cmd,
	spq_rsp_if.source  rsp
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_nxt;
	logic                      rsp_valid_q;
	logic signed [VALUE_W-1:0] front_q;
	logic                      value_valid_q;
	status_e_t                 status_q;

	logic                      accept;
	logic                      empty;
	logic                      full;
	cell_ctl_t                 ctl;
	logic signed [VALUE_W-1:0] front_nxt;
	logic                      value_valid_nxt;
	status_e_t                 status_nxt;

	logic signed [VALUE_W-1:0] values [QUEUE_DEPTH];
	logic                      gts    [QUEUE_DEPTH];

	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;
	assign empty     = (count_q == '0);
	assign full      = (count_q == DEPTH_C);

	always_comb begin
		ctl             = '0;
		count_nxt       = count_q;
		front_nxt       = '0;
		value_valid_nxt = 1'b0;
		status_nxt      = ST_OK;
		unique case (cmd.command)
			CMD_INSERT: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					ctl.insert = accept;
					count_nxt  = count_q + 1'b1;
				end
			end
			CMD_PEEK: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					front_nxt       = values[0];
					value_valid_nxt = 1'b1;
				end
			end
			CMD_POP: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					front_nxt       = values[0];
					value_valid_nxt = 1'b1;
					ctl.pop         = accept;
					count_nxt       = count_q - 1'b1;
				end
			end
			CMD_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				count_nxt = count_q;
			end
		endcase
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                      left_gt;
		logic signed [VALUE_W-1:0] left_value;
		logic signed [VALUE_W-1:0] right_value;

		if (i == 0) begin : g_head
			assign left_gt    = 1'b0;
			assign left_value = values[0];
		end else begin : g_body
			assign left_gt    = gts[i-1];
			assign left_value = values[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_value = values[i];
		end else begin : g_inner
			assign right_value = values[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.new_value   (cmd.new_value),
			.occupied    (CNT_W'(i) < count_q),
			.at_end      (CNT_W'(i) == count_q),
			.left_gt     (left_gt),
			.left_value  (left_value),
			.right_value (right_value),
			.gt          (gts[i]),
			.value       (values[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			front_q       <= front_nxt;
			value_valid_q <= value_valid_nxt;
			status_q      <= status_nxt;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.front_value = front_q;
	assign rsp.value_valid = value_valid_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = count_q;

	`SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= DEPTH_C, "count above depth")
	`SPQ_ASSERT_NOW(a_full_status, rsp_valid_q && status_q == ST_FULL,
		count_q == DEPTH_C, "full status with room left")
	`SPQ_ASSERT_NOW(a_empty_status, rsp_valid_q && status_q == ST_EMPTY,
		count_q == '0, "empty status with entries held")
	`SPQ_ASSERT_NOW(a_valid_ok, rsp_valid_q && value_valid_q,
		status_q == ST_OK, "value flagged valid on an error")
	`SPQ_ASSERT_NEXT(a_pop_count, accept && cmd.command == CMD_POP && !empty,
		count_q == $past(count_q) - 1'b1, "pop did not drop count")

endmodule

`default_nettype wire
